[hdl/rfof_pkg.sv]
// shared types, codes and register selection for the register file and operand fetch
package rfof_pkg;

   // function codes
   localparam logic [2:0] FN_START = 3'd0;
   localparam logic [2:0] FN_BYTE  = 3'd1;
   localparam logic [2:0] FN_WRITE = 3'd2;
   localparam logic [2:0] FN_READ  = 3'd3;
   localparam logic [2:0] FN_FLAGS = 3'd4;

   // addressing modes
   localparam logic [4:0] ADR_IMPLIED   = 5'd0;
   localparam logic [4:0] ADR_REG       = 5'd1;
   localparam logic [4:0] ADR_REG_REG   = 5'd2;
   localparam logic [4:0] ADR_REG_IMM8  = 5'd3;
   localparam logic [4:0] ADR_REG_IMM16 = 5'd4;
   localparam logic [4:0] ADR_IMM16     = 5'd5;
   localparam logic [4:0] ADR_MEM_REG   = 5'd6;
   localparam logic [4:0] ADR_REG_MEM   = 5'd7;
   localparam logic [4:0] ADR_REG_HLINC = 5'd8;
   localparam logic [4:0] ADR_REG_HLDEC = 5'd9;
   localparam logic [4:0] ADR_HLINC_REG = 5'd10;
   localparam logic [4:0] ADR_HLDEC_REG = 5'd11;
   localparam logic [4:0] ADR_REG_HIGH  = 5'd12;
   localparam logic [4:0] ADR_HIGH_REG  = 5'd13;
   localparam logic [4:0] ADR_HL_SP_OFS = 5'd14;
   localparam logic [4:0] ADR_IMM8      = 5'd15;
   localparam logic [4:0] ADR_ABS_REG   = 5'd16;
   localparam logic [4:0] ADR_IMM16_REG = 5'd17;
   localparam logic [4:0] ADR_MEM_IMM8  = 5'd18;
   localparam logic [4:0] ADR_MEM       = 5'd19;
   localparam logic [4:0] ADR_REG_ABS   = 5'd20;

   // register selectors
   localparam logic [3:0] SEL_A  = 4'd1;
   localparam logic [3:0] SEL_F  = 4'd2;
   localparam logic [3:0] SEL_B  = 4'd3;
   localparam logic [3:0] SEL_C  = 4'd4;
   localparam logic [3:0] SEL_D  = 4'd5;
   localparam logic [3:0] SEL_E  = 4'd6;
   localparam logic [3:0] SEL_H  = 4'd7;
   localparam logic [3:0] SEL_L  = 4'd8;
   localparam logic [3:0] SEL_AF = 4'd9;
   localparam logic [3:0] SEL_BC = 4'd10;
   localparam logic [3:0] SEL_DE = 4'd11;
   localparam logic [3:0] SEL_HL = 4'd12;
   localparam logic [3:0] SEL_PC = 4'd13;
   localparam logic [3:0] SEL_SP = 4'd14;

   // result kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // flag update codes
   localparam logic [1:0] FLAG_CLEAR = 2'd0;
   localparam logic [1:0] FLAG_SET   = 2'd1;

   // fetch phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BYTE1 = 2'd1;
   localparam logic [1:0] PH_BYTE2 = 2'd2;
   localparam logic [1:0] PH_BYTE3 = 2'd3;

   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   typedef struct packed {
      logic [2:0]  func;
      logic        inst_valid;
      logic [4:0]  addr_mode;
      logic [3:0]  reg_first;
      logic [3:0]  reg_second;
      logic [7:0]  bus_byte;
      logic [15:0] write_value;
      logic [1:0]  flag_zero;
      logic [1:0]  flag_subtract;
      logic [1:0]  flag_half;
      logic [1:0]  flag_carry;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] bus_address;
      logic [15:0] fetched_value;
      logic [15:0] memory_destination;
      logic        destination_in_memory;
      logic [15:0] register_value;
      logic [1:0]  bus_cycle_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  f;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [15:0] pc;
      logic [15:0] sp;
   } regs_type;

   typedef struct packed {
      logic        reg_we;
      logic [3:0]  reg_sel;
      logic [15:0] reg_data;
      logic        flag_we;
      logic [1:0]  flag_zero;
      logic [1:0]  flag_subtract;
      logic [1:0]  flag_half;
      logic [1:0]  flag_carry;
      logic        hl_step;
      logic        hl_up;
      logic        pc_inc;
   } wr_cmd_type;

   function automatic logic [15:0] reg_read(regs_type r, logic [3:0] sel);
      logic [15:0] v;
      case (sel)
         SEL_A:   v = {8'h00, r.a};
         SEL_F:   v = {8'h00, r.f};
         SEL_B:   v = {8'h00, r.b};
         SEL_C:   v = {8'h00, r.c};
         SEL_D:   v = {8'h00, r.d};
         SEL_E:   v = {8'h00, r.e};
         SEL_H:   v = {8'h00, r.h};
         SEL_L:   v = {8'h00, r.l};
         SEL_AF:  v = {r.a, r.f};
         SEL_BC:  v = {r.b, r.c};
         SEL_DE:  v = {r.d, r.e};
         SEL_HL:  v = {r.h, r.l};
         SEL_PC:  v = r.pc;
         SEL_SP:  v = r.sp;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

   function automatic logic flag_next(logic [1:0] code, logic cur);
      logic v;
      case (code)
         FLAG_CLEAR: v = 1'b0;
         FLAG_SET:   v = 1'b1;
         default:    v = cur;
      endcase
      return v;
   endfunction

endpackage

[hdl/rfof_regfile.sv]
// byte registers, program counter and stack pointer with their write paths
module rfof_regfile import rfof_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wr_cmd_type cmd,
   output regs_type   regs
);

   regs_type regs_ff;
   regs_type regs_in;

   always_comb begin
      logic [15:0] hl;
      regs_in = regs_ff;
      if (cmd.reg_we) begin
         case (cmd.reg_sel)
            SEL_A:  regs_in.a = cmd.reg_data[7:0];
            SEL_F:  regs_in.f = cmd.reg_data[7:0];
            SEL_B:  regs_in.b = cmd.reg_data[7:0];
            SEL_C:  regs_in.c = cmd.reg_data[7:0];
            SEL_D:  regs_in.d = cmd.reg_data[7:0];
            SEL_E:  regs_in.e = cmd.reg_data[7:0];
            SEL_H:  regs_in.h = cmd.reg_data[7:0];
            SEL_L:  regs_in.l = cmd.reg_data[7:0];
            SEL_AF: {regs_in.a, regs_in.f} = cmd.reg_data;
            SEL_BC: {regs_in.b, regs_in.c} = cmd.reg_data;
            SEL_DE: {regs_in.d, regs_in.e} = cmd.reg_data;
            SEL_HL: {regs_in.h, regs_in.l} = cmd.reg_data;
            SEL_PC: regs_in.pc = cmd.reg_data;
            SEL_SP: regs_in.sp = cmd.reg_data;
            default: begin
            end
         endcase
      end
      if (cmd.flag_we) begin
         regs_in.f[7] = flag_next(cmd.flag_zero, regs_ff.f[7]);
         regs_in.f[6] = flag_next(cmd.flag_subtract, regs_ff.f[6]);
         regs_in.f[5] = flag_next(cmd.flag_half, regs_ff.f[5]);
         regs_in.f[4] = flag_next(cmd.flag_carry, regs_ff.f[4]);
      end
      hl = {regs_ff.h, regs_ff.l};
      if (cmd.hl_step) begin
         if (cmd.hl_up) begin
            {regs_in.h, regs_in.l} = hl + 16'd1;
         end else begin
            {regs_in.h, regs_in.l} = hl - 16'd1;
         end
      end
      if (cmd.pc_inc) begin
         regs_in.pc = regs_ff.pc + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

[hdl/rfof_seq.sv]
// operand fetch sequencer: decodes one word against the fetch state and register file
module rfof_seq import rfof_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    word,
   input  logic       step_en,
   input  regs_type   regs,
   output logic       has_result,
   output rsp_type    result,
   output wr_cmd_type cmd
);

   logic [15:0] fetched_ff, fetched_in;
   logic [15:0] dest_ff, dest_in;
   logic        dmem_ff, dmem_in;
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  pmode_ff, pmode_in;
   logic [3:0]  pr1_ff, pr1_in;
   logic [3:0]  pr2_ff, pr2_in;
   logic [7:0]  low_ff, low_in;
   logic [1:0]  cycles_ff, cycles_in;

   always_comb begin
      regs_type    regs_pc;
      logic [15:0] rd1;
      logic [15:0] rd2;
      logic [15:0] prd1_inc;
      logic [15:0] prd2_inc;
      logic [15:0] pc_next;
      logic [15:0] wide;
      logic        done;
      logic        req;
      logic [15:0] req_addr;
      wr_cmd_type  c;

      pc_next  = regs.pc + 16'd1;
      regs_pc  = regs;
      regs_pc.pc = pc_next;
      rd1      = reg_read(regs, word.reg_first);
      rd2      = reg_read(regs, word.reg_second);
      prd1_inc = reg_read(regs_pc, pr1_ff);
      prd2_inc = reg_read(regs_pc, pr2_ff);
      wide     = {word.bus_byte, low_ff};

      fetched_in = fetched_ff;
      dest_in    = dest_ff;
      dmem_in    = dmem_ff;
      phase_in   = phase_ff;
      pmode_in   = pmode_ff;
      pr1_in     = pr1_ff;
      pr2_in     = pr2_ff;
      low_in     = low_ff;
      cycles_in  = cycles_ff;

      done       = 1'b0;
      req        = 1'b0;
      req_addr   = 16'h0000;
      has_result = 1'b0;
      result     = '0;

      c               = '0;
      c.reg_sel       = word.reg_first;
      c.reg_data      = word.write_value;
      c.flag_zero     = word.flag_zero;
      c.flag_subtract = word.flag_subtract;
      c.flag_half     = word.flag_half;
      c.flag_carry    = word.flag_carry;

      case (word.func)
         FN_START: begin
            dest_in   = 16'h0000;
            dmem_in   = 1'b0;
            cycles_in = 2'd0;
            phase_in  = PH_IDLE;
            pmode_in  = word.addr_mode;
            pr1_in    = word.reg_first;
            pr2_in    = word.reg_second;
            if (!word.inst_valid) begin
               done = 1'b1;
            end else begin
               case (word.addr_mode)
                  ADR_IMPLIED: done = 1'b1;
                  ADR_REG: begin
                     fetched_in = rd1;
                     done = 1'b1;
                  end
                  ADR_REG_REG: begin
                     fetched_in = rd2;
                     done = 1'b1;
                  end
                  ADR_REG_IMM8, ADR_REG_IMM16, ADR_IMM16, ADR_REG_HIGH, ADR_HIGH_REG,
                  ADR_HL_SP_OFS, ADR_IMM8, ADR_ABS_REG, ADR_IMM16_REG, ADR_MEM_IMM8,
                  ADR_REG_ABS: begin
                     phase_in = PH_BYTE1;
                     req = 1'b1;
                     req_addr = regs.pc;
                  end
                  ADR_MEM_REG: begin
                     fetched_in = rd2;
                     dest_in = (word.reg_first == SEL_C) ? (rd1 | HIGH_PAGE) : rd1;
                     dmem_in = 1'b1;
                     done = 1'b1;
                  end
                  ADR_REG_MEM: begin
                     phase_in = PH_BYTE1;
                     req = 1'b1;
                     req_addr = (word.reg_second == SEL_C) ? (rd2 | HIGH_PAGE) : rd2;
                  end
                  ADR_REG_HLINC, ADR_REG_HLDEC: begin
                     phase_in = PH_BYTE1;
                     req = 1'b1;
                     req_addr = rd2;
                  end
                  ADR_HLINC_REG, ADR_HLDEC_REG: begin
                     fetched_in = rd2;
                     dest_in = rd1;
                     dmem_in = 1'b1;
                     c.hl_step = 1'b1;
                     c.hl_up = (word.addr_mode == ADR_HLINC_REG);
                     done = 1'b1;
                  end
                  ADR_MEM: begin
                     dest_in = rd1;
                     dmem_in = 1'b1;
                     phase_in = PH_BYTE1;
                     req = 1'b1;
                     req_addr = rd1;
                  end
                  default: begin
                     has_result = 1'b1;
                     result.kind = KIND_ERROR;
                  end
               endcase
            end
         end
         FN_BYTE: begin
            if (phase_ff != PH_IDLE) begin
               cycles_in = cycles_ff + 2'd1;
               case (pmode_ff)
                  ADR_REG_IMM8, ADR_REG_HIGH, ADR_HL_SP_OFS, ADR_IMM8: begin
                     fetched_in = {8'h00, word.bus_byte};
                     c.pc_inc = 1'b1;
                     done = 1'b1;
                  end
                  ADR_HIGH_REG: begin
                     dest_in = HIGH_PAGE | {8'h00, word.bus_byte};
                     dmem_in = 1'b1;
                     c.pc_inc = 1'b1;
                     done = 1'b1;
                  end
                  ADR_MEM_IMM8: begin
                     fetched_in = {8'h00, word.bus_byte};
                     c.pc_inc = 1'b1;
                     dest_in = prd1_inc;
                     dmem_in = 1'b1;
                     done = 1'b1;
                  end
                  ADR_REG_MEM, ADR_MEM: begin
                     fetched_in = {8'h00, word.bus_byte};
                     done = 1'b1;
                  end
                  ADR_REG_HLINC, ADR_REG_HLDEC: begin
                     fetched_in = {8'h00, word.bus_byte};
                     c.hl_step = 1'b1;
                     c.hl_up = (pmode_ff == ADR_REG_HLINC);
                     done = 1'b1;
                  end
                  ADR_REG_IMM16, ADR_IMM16, ADR_ABS_REG, ADR_IMM16_REG, ADR_REG_ABS: begin
                     case (phase_ff)
                        PH_BYTE1: begin
                           low_in = word.bus_byte;
                           c.pc_inc = 1'b1;
                           phase_in = PH_BYTE2;
                           req = 1'b1;
                           req_addr = pc_next;
                        end
                        PH_BYTE2: begin
                           c.pc_inc = 1'b1;
                           if (pmode_ff == ADR_REG_ABS) begin
                              phase_in = PH_BYTE3;
                              req = 1'b1;
                              req_addr = wide;
                           end else if (pmode_ff == ADR_ABS_REG ||
                                        pmode_ff == ADR_IMM16_REG) begin
                              dest_in = wide;
                              dmem_in = 1'b1;
                              fetched_in = prd2_inc;
                              done = 1'b1;
                           end else begin
                              fetched_in = wide;
                              done = 1'b1;
                           end
                        end
                        default: begin
                           fetched_in = {8'h00, word.bus_byte};
                           done = 1'b1;
                        end
                     endcase
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         FN_WRITE: c.reg_we = 1'b1;
         FN_READ: begin
            has_result = 1'b1;
            result.kind = KIND_READ;
            result.register_value = rd1;
         end
         FN_FLAGS: c.flag_we = 1'b1;
         default: begin
         end
      endcase

      if (done) begin
         phase_in = PH_IDLE;
         has_result = 1'b1;
         result.kind = KIND_DONE;
         result.fetched_value = fetched_in;
         result.memory_destination = dest_in;
         result.destination_in_memory = dmem_in;
         result.bus_cycle_count = cycles_in;
      end
      if (req) begin
         has_result = 1'b1;
         result.kind = KIND_REQUEST;
         result.bus_address = req_addr;
      end

      c.reg_we  = c.reg_we & step_en;
      c.flag_we = c.flag_we & step_en;
      c.hl_step = c.hl_step & step_en;
      c.pc_inc  = c.pc_inc & step_en;
      cmd = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetched_ff <= '0;
         dest_ff    <= '0;
         dmem_ff    <= 1'b0;
         phase_ff   <= PH_IDLE;
         pmode_ff   <= '0;
         pr1_ff     <= '0;
         pr2_ff     <= '0;
         low_ff     <= '0;
         cycles_ff  <= '0;
      end else if (step_en) begin
         fetched_ff <= fetched_in;
         dest_ff    <= dest_in;
         dmem_ff    <= dmem_in;
         phase_ff   <= phase_in;
         pmode_ff   <= pmode_in;
         pr1_ff     <= pr1_in;
         pr2_ff     <= pr2_in;
         low_ff     <= low_in;
         cycles_ff  <= cycles_in;
      end
   end

endmodule

[hdl/cpu_register_file_operand_fetch.sv]
// top level of the register file and operand fetch sequencer
//
//   channel  ports                       direction  payload
//   req      req_valid req_ready req_word   in       req_type
//   rsp      rsp_valid rsp_ready rsp_word   out      rsp_type
//
// one word a cycle while the output register can take its result; a word is held in the
// input register while the sequencer and register file act on it, and any result lands in the output register
// a word that gives no result moves on even while a result waits to be taken
// a word that gives a result waits in the input register while the output register is
// full and rsp_ready is low
// reset is synchronous and clears all registers, program counter and fetch state at once
module cpu_register_file_operand_fetch import rfof_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_word_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_word_ff;
   logic       has_result;
   rsp_type    result;
   wr_cmd_type cmd;
   regs_type   regs;
   logic       step;

   rfof_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .regs  (regs)
   );

   rfof_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .word       (in_word_ff),
      .step_en    (step),
      .regs       (regs),
      .has_result (has_result),
      .result     (result),
      .cmd        (cmd)
   );

   assign step      = in_valid_ff & (~has_result | ~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (step && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
      if (step && has_result) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
